[sv/cmi_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// cmi_pkg
// Shared constants and types for the complex magnitude block.
// ============================================================================
package cmi_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MAG_WIDTH        = 16;

    typedef logic [MAG_WIDTH-1:0] mag_t;

    // magnitude clamps here when the parameter is raised past 16 bits
    localparam mag_t MAG_MAX = '1;

endpackage

[sv/cmi_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// cmi_bin_if / cmi_mag_if
// Valid/ready channels for complex bins in and magnitudes out.
// ============================================================================
interface cmi_bin_if #(
    parameter int SAMPLE_WIDTH = cmi_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] real_part;
    logic signed [SAMPLE_WIDTH-1:0] imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface cmi_mag_if;
    logic           valid;
    logic           ready;
    cmi_pkg::mag_t  magnitude;

    modport source (output valid, output magnitude, input ready);
    modport sink   (input valid, input magnitude, output ready);
endinterface

[sv/cmi_sqrt_stage.sv]
`timescale 1ns / 1ps
// ============================================================================
// cmi_sqrt_stage
// One registered digit of the bit-pair square root: decides root bit BIT_POS.
// ============================================================================
module cmi_sqrt_stage #(
    parameter int SAMPLE_WIDTH = cmi_pkg::SAMPLE_WIDTH_DEF,
    parameter int BIT_POS      = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic [2*SAMPLE_WIDTH-1:0] in_rem,
    input  logic [SAMPLE_WIDTH-1:0]   in_root,
    output logic                      out_valid,
    output logic [2*SAMPLE_WIDTH-1:0] out_rem,
    output logic [SAMPLE_WIDTH-1:0]   out_root
);
    localparam int SUM_W = 2 * SAMPLE_WIDTH;

    logic                    valid_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [SUM_W-1:0]        rem_next;
    logic [SAMPLE_WIDTH-1:0] root_reg;
    logic [SAMPLE_WIDTH-1:0] root_next;
    logic [SUM_W-1:0]        trial;
    logic                    fits;

    // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    always_comb
    begin
        trial     = (SUM_W'(in_root) << (BIT_POS + 1)) | (SUM_W'(1) << (2 * BIT_POS));
        fits      = (in_rem >= trial);
        rem_next  = fits ? (in_rem - trial) : in_rem;
        root_next = fits ? (in_root | (SAMPLE_WIDTH'(1) << BIT_POS)) : in_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

[sv/complex_magnitude_isqrt.sv]
`timescale 1ns / 1ps
// ============================================================================
// complex_magnitude_isqrt
// Magnitude of a complex bin: floor(sqrt(re^2 + im^2)), fully pipelined.
// ============================================================================
// Takes one bin per cycle while bin.ready is high and returns one 16-bit
// magnitude per bin, in order. The stages are absolute value, square, sum,
// then one register stage per root bit, then the output register.
// Throughput is one beat per cycle while bin.ready is high. A two-entry
// output (register plus skid) keeps bin.ready registered; the pipeline holds
// only while the skid entry is occupied. With SAMPLE_WIDTH above 16 the
// magnitude clamps at 0xFFFF.
module complex_magnitude_isqrt #(
    parameter int SAMPLE_WIDTH = cmi_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cmi_bin_if.sink   bin,
    cmi_mag_if.source mag
);
    import cmi_pkg::*;

    localparam int SUM_W = 2 * SAMPLE_WIDTH;

    logic advance;

    // stage A: absolute values
    logic                    abs_valid_reg;
    logic [SAMPLE_WIDTH-1:0] abs_re_reg;
    logic [SAMPLE_WIDTH-1:0] abs_im_reg;
    logic [SAMPLE_WIDTH-1:0] abs_re_next;
    logic [SAMPLE_WIDTH-1:0] abs_im_next;

    // stage B: squares
    logic             sq_valid_reg;
    logic [SUM_W-1:0] sq_re_reg;
    logic [SUM_W-1:0] sq_im_reg;

    // stage C: sum
    logic             sum_valid_reg;
    logic [SUM_W-1:0] sum_reg;

    // root digit stages
    logic                    dig_valid [0:SAMPLE_WIDTH];
    logic [SUM_W-1:0]        dig_rem   [0:SAMPLE_WIDTH];
    logic [SAMPLE_WIDTH-1:0] dig_root  [0:SAMPLE_WIDTH];

    // output register and skid entry
    logic out_valid_reg;
    mag_t out_mag_reg;
    logic skid_valid_reg;
    mag_t skid_mag_reg;
    mag_t sat_mag;
    logic pipe_valid;

    assign advance   = !skid_valid_reg;
    assign bin.ready = advance;

    // -2^(W-1) maps to 2^(W-1), which still fits W unsigned bits
    always_comb
    begin
        abs_re_next = bin.real_part[SAMPLE_WIDTH-1] ?
                      (~bin.real_part + SAMPLE_WIDTH'(1)) : bin.real_part;
        abs_im_next = bin.imag_part[SAMPLE_WIDTH-1] ?
                      (~bin.imag_part + SAMPLE_WIDTH'(1)) : bin.imag_part;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            abs_valid_reg <= bin.valid;
            sq_valid_reg  <= abs_valid_reg;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            abs_re_reg <= abs_re_next;
            abs_im_reg <= abs_im_next;
            sq_re_reg  <= SUM_W'(abs_re_reg) * SUM_W'(abs_re_reg);
            sq_im_reg  <= SUM_W'(abs_im_reg) * SUM_W'(abs_im_reg);
            sum_reg    <= sq_re_reg + sq_im_reg;
        end
    end

    assign dig_valid[0] = sum_valid_reg;
    assign dig_rem[0]   = sum_reg;
    assign dig_root[0]  = '0;

    for (genvar k = 0; k < SAMPLE_WIDTH; k++)
    begin : g_digit
        cmi_sqrt_stage #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .BIT_POS      (SAMPLE_WIDTH - 1 - k)
        ) u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (dig_valid[k]),
            .in_rem    (dig_rem[k]),
            .in_root   (dig_root[k]),
            .out_valid (dig_valid[k+1]),
            .out_rem   (dig_rem[k+1]),
            .out_root  (dig_root[k+1])
        );
    end

    assign pipe_valid = dig_valid[SAMPLE_WIDTH];

    if (SAMPLE_WIDTH > MAG_WIDTH)
    begin : g_sat
        assign sat_mag = (|dig_root[SAMPLE_WIDTH][SAMPLE_WIDTH-1:MAG_WIDTH]) ?
                         MAG_MAX : dig_root[SAMPLE_WIDTH][MAG_WIDTH-1:0];
    end
    else
    begin : g_nosat
        assign sat_mag = mag_t'(dig_root[SAMPLE_WIDTH]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (mag.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || mag.ready)
        begin
            out_valid_reg <= pipe_valid;
        end
        else if (pipe_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (mag.ready)
            begin
                out_mag_reg <= skid_mag_reg;
            end
        end
        else if (!out_valid_reg || mag.ready)
        begin
            out_mag_reg <= sat_mag;
        end
        else
        begin
            skid_mag_reg <= sat_mag;
        end
    end

    assign mag.valid     = out_valid_reg;
    assign mag.magnitude = out_mag_reg;

endmodule
